>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the im2col copy-pair generator files.
// Defining NO_ASSERTIONS removes every check from the build.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// A condition in one cycle that forces a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// A condition in one cycle that forces a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/i2c_pkg.sv
// ---------------------------------------------------------------------------
// im2col copy-pair generator package
// Widths, limits, register indexes and the structs passed between modules.
// ---------------------------------------------------------------------------
package i2c_pkg;

   // Limits of the usable configuration.
   localparam int MAX_DIM      = 1024;
   localparam int MAX_CHANNELS = 4096;
   localparam int MAX_KERNEL   = 15;

   // Field widths.
   localparam int CFG_DIM_W = 11;
   localparam int CH_W      = 13;
   localparam int K_W       = 4;
   localparam int POS_W     = 10;
   localparam int MAT_W     = 20;
   localparam int IDX_W     = 3;

   // Register indexes of the configuration port.
   localparam logic [IDX_W-1:0] REG_IN_WIDTH    = 3'd0;
   localparam logic [IDX_W-1:0] REG_IN_HEIGHT   = 3'd1;
   localparam logic [IDX_W-1:0] REG_CHANNELS    = 3'd2;
   localparam logic [IDX_W-1:0] REG_KERNEL_SIZE = 3'd3;
   localparam logic [IDX_W-1:0] REG_STRIDE      = 3'd4;

   // Register reset values.
   localparam logic [CFG_DIM_W-1:0] RST_IN_WIDTH    = 11'd1;
   localparam logic [CFG_DIM_W-1:0] RST_IN_HEIGHT   = 11'd1;
   localparam logic [CH_W-1:0]      RST_CHANNELS    = 13'd1;
   localparam logic [K_W-1:0]       RST_KERNEL_SIZE = 4'd3;
   localparam logic [K_W-1:0]       RST_STRIDE      = 4'd1;

   // Configuration after clamping, as the scan uses it.
   typedef struct packed {
      logic [CFG_DIM_W-1:0] width;
      logic [CFG_DIM_W-1:0] height;
      logic [CH_W-1:0]      channels;
      logic [K_W-1:0]       kernel;
      logic [K_W-1:0]       stride;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      logic [POS_W-1:0] src_row;
      logic [POS_W-1:0] src_col;
      logic [MAT_W-1:0] dst_row;
      logic [MAT_W-1:0] dst_col_start;
      logic [MAT_W-1:0] dst_col_end;
      logic             last;
      logic             exhausted;
   } rsp_type;

endpackage

>>> rtl/i2c_csr.sv
// ---------------------------------------------------------------------------
// im2col configuration registers
// Holds the five registers and presents them clamped to their usable range.
// ---------------------------------------------------------------------------
module i2c_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [i2c_pkg::IDX_W-1:0]    csr_index,
   input  logic [31:0]                  csr_data,
   output i2c_pkg::cfg_type             cfg
);

   logic [i2c_pkg::CFG_DIM_W-1:0] in_width_ff;
   logic [i2c_pkg::CFG_DIM_W-1:0] in_height_ff;
   logic [i2c_pkg::CH_W-1:0]      channels_ff;
   logic [i2c_pkg::K_W-1:0]       kernel_ff;
   logic [i2c_pkg::K_W-1:0]       stride_ff;

   assign csr_ready = 1'b1;

   // Register writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= i2c_pkg::RST_IN_WIDTH;
         in_height_ff <= i2c_pkg::RST_IN_HEIGHT;
         channels_ff  <= i2c_pkg::RST_CHANNELS;
         kernel_ff    <= i2c_pkg::RST_KERNEL_SIZE;
         stride_ff    <= i2c_pkg::RST_STRIDE;
      end else if (csr_valid) begin
         case (csr_index)
            i2c_pkg::REG_IN_WIDTH:    in_width_ff  <= csr_data[i2c_pkg::CFG_DIM_W-1:0];
            i2c_pkg::REG_IN_HEIGHT:   in_height_ff <= csr_data[i2c_pkg::CFG_DIM_W-1:0];
            i2c_pkg::REG_CHANNELS:    channels_ff  <= csr_data[i2c_pkg::CH_W-1:0];
            i2c_pkg::REG_KERNEL_SIZE: kernel_ff    <= csr_data[i2c_pkg::K_W-1:0];
            i2c_pkg::REG_STRIDE:      stride_ff    <= csr_data[i2c_pkg::K_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp to the supported limits; a zero stride acts as one.
   always_comb begin
      cfg.width    = (in_width_ff > i2c_pkg::CFG_DIM_W'(i2c_pkg::MAX_DIM)) ?
                     i2c_pkg::CFG_DIM_W'(i2c_pkg::MAX_DIM) : in_width_ff;
      cfg.height   = (in_height_ff > i2c_pkg::CFG_DIM_W'(i2c_pkg::MAX_DIM)) ?
                     i2c_pkg::CFG_DIM_W'(i2c_pkg::MAX_DIM) : in_height_ff;
      cfg.channels = (channels_ff > i2c_pkg::CH_W'(i2c_pkg::MAX_CHANNELS)) ?
                     i2c_pkg::CH_W'(i2c_pkg::MAX_CHANNELS) : channels_ff;
      cfg.kernel   = (kernel_ff > i2c_pkg::K_W'(i2c_pkg::MAX_KERNEL)) ?
                     i2c_pkg::K_W'(i2c_pkg::MAX_KERNEL) : kernel_ff;
      cfg.stride   = (stride_ff == '0) ? i2c_pkg::K_W'(1) : stride_ff;
   end

endmodule

>>> rtl/i2c_scan.sv
// ---------------------------------------------------------------------------
// im2col scan counters
// Nested window and kernel counters; forms the pair for the current
// position and advances on each accepted request beat.
// ---------------------------------------------------------------------------
module i2c_scan (
   input  logic              clock,
   input  logic              reset,
   input  i2c_pkg::cfg_type  cfg,
   input  logic              step,
   input  logic              restart,
   output i2c_pkg::rsp_type  rsp
);

   localparam int CMP_W = i2c_pkg::CFG_DIM_W + 1;

   logic [i2c_pkg::POS_W-1:0] window_col_ff, window_col_in;
   logic [i2c_pkg::POS_W-1:0] window_row_ff, window_row_in;
   logic [i2c_pkg::K_W-1:0]   kern_col_ff, kern_col_in;
   logic [i2c_pkg::K_W-1:0]   kern_row_ff, kern_row_in;
   logic [i2c_pkg::MAT_W-1:0] out_row_ff, out_row_in;
   logic [i2c_pkg::MAT_W-1:0] out_col_ff, out_col_in;
   logic                      done_ff, done_in;

   // Position after an optional rewind.
   logic [i2c_pkg::POS_W-1:0] wc, wr;
   logic [i2c_pkg::K_W-1:0]   kc, kr;
   logic [i2c_pkg::MAT_W-1:0] orow, ocol;
   logic                      done_cur, out_of_range;
   logic [i2c_pkg::K_W:0]     kr_inc, kc_inc;
   logic [CMP_W-1:0]          wc_next, wr_next;
   logic [i2c_pkg::MAT_W-1:0] col_next;

   always_comb begin
      wc       = restart ? '0 : window_col_ff;
      wr       = restart ? '0 : window_row_ff;
      kc       = restart ? '0 : kern_col_ff;
      kr       = restart ? '0 : kern_row_ff;
      orow     = restart ? '0 : out_row_ff;
      ocol     = restart ? '0 : out_col_ff;
      done_cur = restart ? 1'b0 : done_ff;

      // The position is rechecked against the live registers.
      out_of_range = (cfg.kernel == '0)
         || ((CMP_W'(wc) + CMP_W'(cfg.kernel)) > CMP_W'(cfg.width))
         || ((CMP_W'(wr) + CMP_W'(cfg.kernel)) > CMP_W'(cfg.height))
         || (kc >= cfg.kernel) || (kr >= cfg.kernel);

      kr_inc   = {1'b0, kr} + (i2c_pkg::K_W+1)'(1);
      kc_inc   = {1'b0, kc} + (i2c_pkg::K_W+1)'(1);
      wc_next  = CMP_W'(wc) + CMP_W'(cfg.stride);
      wr_next  = CMP_W'(wr) + CMP_W'(cfg.stride);
      col_next = ocol + i2c_pkg::MAT_W'(cfg.channels);

      // Hold the (rewound) position by default.
      window_col_in = wc;
      window_row_in = wr;
      kern_col_in   = kc;
      kern_row_in   = kr;
      out_row_in    = orow;
      out_col_in    = ocol;
      done_in       = done_cur;

      if (done_cur || out_of_range) begin
         done_in = 1'b1;
      end else begin
         // Kernel row innermost, then kernel column, then window row, then column.
         out_col_in  = col_next;
         kern_row_in = kr_inc[i2c_pkg::K_W-1:0];
         if (kr_inc >= {1'b0, cfg.kernel}) begin
            kern_row_in = '0;
            kern_col_in = kc_inc[i2c_pkg::K_W-1:0];
            if (kc_inc >= {1'b0, cfg.kernel}) begin
               kern_col_in = '0;
               out_row_in  = orow + i2c_pkg::MAT_W'(1);
               out_col_in  = '0;
               if ((wr_next + CMP_W'(cfg.kernel)) > CMP_W'(cfg.height)) begin
                  window_row_in = '0;
                  if ((wc_next + CMP_W'(cfg.kernel)) > CMP_W'(cfg.width)) begin
                     done_in = 1'b1;
                  end else begin
                     window_col_in = wc_next[i2c_pkg::POS_W-1:0];
                  end
               end else begin
                  window_row_in = wr_next[i2c_pkg::POS_W-1:0];
               end
            end
         end
      end
   end

   // Result beat for the current position.
   always_comb begin
      rsp = '0;
      if (done_cur || out_of_range) begin
         rsp.exhausted = 1'b1;
      end else begin
         rsp.src_row       = wr + i2c_pkg::POS_W'(kr);
         rsp.src_col       = wc + i2c_pkg::POS_W'(kc);
         rsp.dst_row       = orow;
         rsp.dst_col_start = ocol;
         rsp.dst_col_end   = col_next - i2c_pkg::MAT_W'(1);
         rsp.last          = done_in;
      end
   end

   // Scan state advances only on an accepted request beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_col_ff <= '0;
         window_row_ff <= '0;
         kern_col_ff   <= '0;
         kern_row_ff   <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         done_ff       <= 1'b0;
      end else if (step) begin
         window_col_ff <= window_col_in;
         window_row_ff <= window_row_in;
         kern_col_ff   <= kern_col_in;
         kern_row_ff   <= kern_row_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         done_ff       <= done_in;
      end
   end

endmodule

>>> rtl/i2c_out_reg.sv
// ---------------------------------------------------------------------------
// im2col result register
// Holds one result beat until the consumer takes it, and loads a new one
// in the same cycle that the old one leaves.
// ---------------------------------------------------------------------------
module i2c_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  i2c_pkg::rsp_type  rsp_next,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              can_load,
   output i2c_pkg::rsp_type  rsp_out
);

   logic             valid_ff, valid_in;
   i2c_pkg::rsp_type data_ff;

   assign can_load  = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign rsp_out   = data_ff;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

endmodule

>>> rtl/im2col_copy_pair_generator_core.sv
// ---------------------------------------------------------------------------
// im2col copy-pair generator
// The result beat appears in the cycle after its request beat is accepted.
// Throughput: one pair per cycle, set by the scan counter update, while the consumer takes each result.
// A new request is taken while the previous result is being taken.
// Reset (synchronous, active high) rewinds the scan and loads register defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module im2col_copy_pair_generator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [i2c_pkg::IDX_W-1:0]     csr_index,
   input  logic [31:0]                   csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [i2c_pkg::POS_W-1:0]     rsp_src_row,
   output logic [i2c_pkg::POS_W-1:0]     rsp_src_col,
   output logic [i2c_pkg::MAT_W-1:0]     rsp_dst_row,
   output logic [i2c_pkg::MAT_W-1:0]     rsp_dst_col_start,
   output logic [i2c_pkg::MAT_W-1:0]     rsp_dst_col_end,
   output logic                          rsp_last,
   output logic                          rsp_exhausted
);

   i2c_pkg::cfg_type cfg;
   i2c_pkg::rsp_type rsp_next;
   i2c_pkg::rsp_type rsp_out;
   logic             req_fire;

   assign req_fire = req_valid && req_ready;

   // Configuration registers.
   i2c_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Scan counters and pair formation.
   i2c_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (req_fire),
      .restart (req_restart),
      .rsp     (rsp_next)
   );

   // Result register.
   i2c_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .rsp_next  (rsp_next),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .can_load  (req_ready),
      .rsp_out   (rsp_out)
   );

   assign rsp_src_row       = rsp_out.src_row;
   assign rsp_src_col       = rsp_out.src_col;
   assign rsp_dst_row       = rsp_out.dst_row;
   assign rsp_dst_col_start = rsp_out.dst_col_start;
   assign rsp_dst_col_end   = rsp_out.dst_col_end;
   assign rsp_last          = rsp_out.last;
   assign rsp_exhausted     = rsp_out.exhausted;

   // An exhausted beat carries no pair and is never the last one.
   `ASSERT_IMPLY(a_exhausted_zero, clock, reset, rsp_valid && rsp_exhausted, rsp_src_row == '0 && rsp_src_col == '0 && rsp_dst_row == '0 && rsp_dst_col_start == '0 && rsp_dst_col_end == '0 && !rsp_last)

   // A stalled result blocks new requests.
   `ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // Every accepted request beat shows a result beat in the next cycle.
   `ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

endmodule

>>> sim/im2col_copy_pair_generator_core_tb.sv
// ---------------------------------------------------------------------------
// Testbench for the im2col copy-pair generator core
// A queue of request beats feeds a driver; a monitor predicts each copy pair
// from its own copy of the scan counters and registers and checks every
// result beat field by field. Directed scans cover empty maps, clamped
// sizes, zero kernel, zero stride, zero channels and register changes in
// the middle of a scan. Random phases follow under varied settings and
// random stalls on both channels.
// ---------------------------------------------------------------------------
module im2col_copy_pair_generator_core_tb;

   localparam int RANDOM_ITEMS   = 1400;
   localparam int CALM_PHASE     = 3;
   localparam int HOLD_AFTER     = 500;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_CYCLES   = 3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_PRINTS     = 40;
   localparam int SCAN_CAP       = 150;

   // Unused register indexes; writes to them must change nothing.
   localparam logic [i2c_pkg::IDX_W-1:0] REG_UNUSED_FIRST = i2c_pkg::REG_STRIDE + 3'd1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [i2c_pkg::IDX_W-1:0]     csr_index = '0;
   logic [31:0]                   csr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [i2c_pkg::POS_W-1:0]     rsp_src_row;
   logic [i2c_pkg::POS_W-1:0]     rsp_src_col;
   logic [i2c_pkg::MAT_W-1:0]     rsp_dst_row;
   logic [i2c_pkg::MAT_W-1:0]     rsp_dst_col_start;
   logic [i2c_pkg::MAT_W-1:0]     rsp_dst_col_end;
   logic                          rsp_last;
   logic                          rsp_exhausted;

   // Stimulus and scoreboard storage.
   logic                          restart_q[$];
   i2c_pkg::rsp_type              pair_q[$];
   logic                          req_fire = 1'b0;
   logic                          rsp_hold = 1'b0;
   int                            send_idle = 25;
   int                            recv_idle = 25;

   // Mirror of the registers and the scan counters.
   i2c_pkg::cfg_type              scan_cfg;
   logic [i2c_pkg::POS_W-1:0]     win_col, win_row;
   logic [i2c_pkg::K_W-1:0]       kern_col, kern_row;
   logic [i2c_pkg::MAT_W-1:0]     mat_row, mat_col;
   logic                          scan_done;
   i2c_pkg::rsp_type              next_pair, seen_pair, want_pair;

   // Run statistics.
   int                            err_count = 0;
   int                            req_count = 0;
   int                            pair_count = 0;
   int                            exhausted_count = 0;
   int                            csr_count = 0;
   int                            queued_items = 0;
   int                            phase_count = 0;
   int                            stall_cycles = 0;

   im2col_copy_pair_generator_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_src_row       (rsp_src_row),
      .rsp_src_col       (rsp_src_col),
      .rsp_dst_row       (rsp_dst_row),
      .rsp_dst_col_start (rsp_dst_col_start),
      .rsp_dst_col_end   (rsp_dst_col_end),
      .rsp_last          (rsp_last),
      .rsp_exhausted     (rsp_exhausted)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Prints one mismatch line, up to a cap, and counts every one.
   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (err_count < MAX_PRINTS)
         $display("%0t: %s mismatch on pair %0d: got %h, expected %h",
                  $time, what, pair_count, got, want);
      err_count++;
   endtask

   task automatic rewind_scan();
      win_col   = '0;
      win_row   = '0;
      kern_col  = '0;
      kern_row  = '0;
      mat_row   = '0;
      mat_col   = '0;
      scan_done = 1'b0;
   endtask

   // Works out the copy pair for one request and steps the scan counters.
   task automatic predict_pair(input logic restart, output i2c_pkg::rsp_type pair);
      int w, h, c, k, st;
      w  = scan_cfg.width;
      h  = scan_cfg.height;
      c  = scan_cfg.channels;
      k  = scan_cfg.kernel;
      st = scan_cfg.stride;
      if (w > i2c_pkg::MAX_DIM) w = i2c_pkg::MAX_DIM;
      if (h > i2c_pkg::MAX_DIM) h = i2c_pkg::MAX_DIM;
      if (c > i2c_pkg::MAX_CHANNELS) c = i2c_pkg::MAX_CHANNELS;
      if (k > i2c_pkg::MAX_KERNEL) k = i2c_pkg::MAX_KERNEL;
      if (st == 0) st = 1;
      if (restart) rewind_scan();
      pair = '0;
      // A position outside the current map ends the scan.
      if (!scan_done && (k == 0 || win_col + k > w || win_row + k > h ||
                         kern_col >= k || kern_row >= k))
         scan_done = 1'b1;
      if (scan_done) begin
         pair.exhausted = 1'b1;
      end else begin
         pair.src_row       = win_row + kern_row;
         pair.src_col       = win_col + kern_col;
         pair.dst_row       = mat_row;
         pair.dst_col_start = mat_col;
         pair.dst_col_end   = i2c_pkg::MAT_W'(mat_col + c - 1);
         mat_col  = i2c_pkg::MAT_W'(mat_col + c);
         kern_row = kern_row + 1'b1;
         // Kernel row is innermost, then kernel column, then the window.
         if (kern_row >= k) begin
            kern_row = '0;
            kern_col = kern_col + 1'b1;
            if (kern_col >= k) begin
               kern_col = '0;
               mat_row  = mat_row + 1'b1;
               mat_col  = '0;
               if (win_row + st + k > h) begin
                  win_row = '0;
                  if (win_col + st + k > w)
                     scan_done = 1'b1;
                  else
                     win_col = i2c_pkg::POS_W'(win_col + st);
               end else begin
                  win_row = i2c_pkg::POS_W'(win_row + st);
               end
            end
         end
         pair.last = scan_done;
      end
   endtask

   // Request driver: a new beat is offered only once the last one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (restart_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            req_valid   <= 1'b1;
            req_restart <= restart_q.pop_front();
         end else begin
            req_valid   <= 1'b0;
            req_restart <= 1'b0;
         end
      end
   end

   // Result receiver with random stalls and one long hold-off.
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle);
   end

   // Monitor: mirrors register writes, predicts on each request beat and
   // checks each result beat against the oldest expected pair.
   always @(posedge clock) begin
      if (reset) begin
         scan_cfg.width    = i2c_pkg::RST_IN_WIDTH;
         scan_cfg.height   = i2c_pkg::RST_IN_HEIGHT;
         scan_cfg.channels = i2c_pkg::RST_CHANNELS;
         scan_cfg.kernel   = i2c_pkg::RST_KERNEL_SIZE;
         scan_cfg.stride   = i2c_pkg::RST_STRIDE;
         rewind_scan();
         pair_q.delete();
         req_fire <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            csr_count++;
            case (csr_index)
               i2c_pkg::REG_IN_WIDTH:
                  scan_cfg.width    = csr_data[i2c_pkg::CFG_DIM_W-1:0];
               i2c_pkg::REG_IN_HEIGHT:
                  scan_cfg.height   = csr_data[i2c_pkg::CFG_DIM_W-1:0];
               i2c_pkg::REG_CHANNELS:
                  scan_cfg.channels = csr_data[i2c_pkg::CH_W-1:0];
               i2c_pkg::REG_KERNEL_SIZE:
                  scan_cfg.kernel   = csr_data[i2c_pkg::K_W-1:0];
               i2c_pkg::REG_STRIDE:
                  scan_cfg.stride   = csr_data[i2c_pkg::K_W-1:0];
               default: ;
            endcase
         end
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_pair(req_restart, next_pair);
            pair_q.insert(pair_q.size(), next_pair);
            req_count++;
         end
         if (rsp_valid && rsp_ready) begin
            seen_pair = {rsp_src_row, rsp_src_col, rsp_dst_row, rsp_dst_col_start,
                         rsp_dst_col_end, rsp_last, rsp_exhausted};
            if (pair_q.size() == 0) begin
               flag_mismatch("unexpected result beat", 32'd1, 32'd0);
            end else begin
               want_pair = pair_q.pop_front();
               if (seen_pair.src_row !== want_pair.src_row)
                  flag_mismatch("src_row", 32'(seen_pair.src_row),
                                32'(want_pair.src_row));
               if (seen_pair.src_col !== want_pair.src_col)
                  flag_mismatch("src_col", 32'(seen_pair.src_col),
                                32'(want_pair.src_col));
               if (seen_pair.dst_row !== want_pair.dst_row)
                  flag_mismatch("dst_row", 32'(seen_pair.dst_row),
                                32'(want_pair.dst_row));
               if (seen_pair.dst_col_start !== want_pair.dst_col_start)
                  flag_mismatch("dst_col_start", 32'(seen_pair.dst_col_start),
                                32'(want_pair.dst_col_start));
               if (seen_pair.dst_col_end !== want_pair.dst_col_end)
                  flag_mismatch("dst_col_end", 32'(seen_pair.dst_col_end),
                                32'(want_pair.dst_col_end));
               if (seen_pair.last !== want_pair.last)
                  flag_mismatch("last", 32'(seen_pair.last), 32'(want_pair.last));
               if (seen_pair.exhausted !== want_pair.exhausted)
                  flag_mismatch("exhausted", 32'(seen_pair.exhausted),
                                32'(want_pair.exhausted));
               if (want_pair.exhausted) exhausted_count++;
            end
            pair_count++;
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Long receiver hold-off while the sender still has beats to offer.
   initial begin
      @(negedge clock);
      while (!(req_count >= HOLD_AFTER && restart_q.size() > 40)) @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic queue_item(input logic restart);
      restart_q.insert(restart_q.size(), restart);
      queued_items++;
   endtask

   task automatic write_reg(input logic [i2c_pkg::IDX_W-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes all five registers; junk fills the unused upper data bits.
   task automatic set_scan(input int w, input int h, input int c, input int k,
                           input int s, input bit junk);
      logic [31:0] noise;
      noise = junk ? $urandom() : 32'd0;
      write_reg(i2c_pkg::REG_IN_WIDTH,
                {noise[31:i2c_pkg::CFG_DIM_W], w[i2c_pkg::CFG_DIM_W-1:0]});
      write_reg(i2c_pkg::REG_IN_HEIGHT,
                {noise[31:i2c_pkg::CFG_DIM_W], h[i2c_pkg::CFG_DIM_W-1:0]});
      write_reg(i2c_pkg::REG_CHANNELS,
                {noise[31:i2c_pkg::CH_W], c[i2c_pkg::CH_W-1:0]});
      write_reg(i2c_pkg::REG_KERNEL_SIZE,
                {noise[31:i2c_pkg::K_W], k[i2c_pkg::K_W-1:0]});
      write_reg(i2c_pkg::REG_STRIDE,
                {noise[31:i2c_pkg::K_W], s[i2c_pkg::K_W-1:0]});
   endtask

   // Waits until every queued beat is sent and every pair has come back.
   task automatic wait_idle();
      @(negedge clock);
      while (restart_q.size() != 0 || req_valid || pair_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int random_start, batch, added, pairs, extra, i;
      int w, h, c, k, s, cw, ch, st;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values put a 3x3 kernel on a 1x1 map: nothing to scan.
      queue_item(1'b0);
      queue_item(1'b1);
      wait_idle();

      // A small map scanned to its end, one exhausted answer, then a rewind.
      set_scan(3, 2, 5, 2, 1, 1'b0);
      queue_item(1'b1);
      repeat (8) queue_item(1'b0);
      queue_item(1'b1);
      wait_idle();

      // Oversized width, height and channels are clamped; largest kernel.
      set_scan(2047, 2047, 8191, 15, 15, 1'b1);
      queue_item(1'b1);
      queue_item(1'b0);
      queue_item(1'b0);
      wait_idle();

      // A zero kernel holds no pair at all.
      write_reg(i2c_pkg::REG_KERNEL_SIZE, 32'd0);
      queue_item(1'b1);
      wait_idle();

      // Zero stride acts as one; zero channels wrap the end column.
      set_scan(3, 1, 0, 1, 0, 1'b0);
      queue_item(1'b1);
      repeat (3) queue_item(1'b0);
      wait_idle();

      // Registers changed mid-scan: a new channel count continues the
      // scan, a width that no longer fits the window ends it.
      set_scan(5, 5, 3, 2, 2, 1'b0);
      queue_item(1'b1);
      queue_item(1'b0);
      queue_item(1'b0);
      wait_idle();
      write_reg(i2c_pkg::REG_CHANNELS, 32'd7);
      queue_item(1'b0);
      wait_idle();
      write_reg(i2c_pkg::REG_IN_WIDTH, 32'd1);
      queue_item(1'b0);
      wait_idle();

      // Random phases: a fresh setting, then mostly complete scans.
      random_start = queued_items;
      while (queued_items - random_start < RANDOM_ITEMS) begin
         phase_count++;
         send_idle <= (phase_count == CALM_PHASE) ? 0 : 25;
         recv_idle <= (phase_count == CALM_PHASE) ? 0 : 25;
         if ($urandom_range(0, 7) == 0) begin
            w = $urandom_range(0, 2047);
            h = $urandom_range(0, 2047);
            c = $urandom_range(0, 8191);
            k = $urandom_range(0, 15);
            s = $urandom_range(0, 15);
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                            : $urandom_range(1, 64);
            k = $urandom_range(1, 4);
            s = $urandom_range(1, 3);
         end
         set_scan(w, h, c, k, s, $urandom_range(0, 1));
         if ($urandom_range(0, 4) == 0)
            write_reg(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), $urandom());

         // Length of a full scan under this setting; a longer one is cut to a random length.
         cw = (w > i2c_pkg::MAX_DIM) ? i2c_pkg::MAX_DIM : w;
         ch = (h > i2c_pkg::MAX_DIM) ? i2c_pkg::MAX_DIM : h;
         st = (s == 0) ? 1 : s;
         if (k == 0 || k > cw || k > ch)
            pairs = 0;
         else
            pairs = ((cw - k) / st + 1) * ((ch - k) / st + 1) * k * k;
         if (pairs > SCAN_CAP) pairs = $urandom_range(20, SCAN_CAP);

         batch = $urandom_range(60, 180);
         added = queued_items;
         // Sometimes the old scan carries on under the new setting.
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) queue_item(1'b0);
         while (queued_items - added < batch) begin
            if ($urandom_range(0, 99) < 85) begin
               extra = $urandom_range(0, 2);
               queue_item(1'b1);
               for (i = 1; i < pairs + extra; i++) queue_item(1'b0);
            end else begin
               repeat ($urandom_range(1, 5)) queue_item($urandom_range(0, 1));
            end
         end
         wait_idle();
      end

      $display("Covered %0d request beats (%0d exhausted answers) over %0d random",
               req_count, exhausted_count, phase_count);
      $display("settings and %0d register writes, with a long receiver hold-off.",
               csr_count);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches found", err_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> im2col_copy_pair_generator_core.f
+incdir+rtl
rtl/i2c_pkg.sv
rtl/i2c_csr.sv
rtl/i2c_scan.sv
rtl/i2c_out_reg.sv
rtl/im2col_copy_pair_generator_core.sv
sim/im2col_copy_pair_generator_core_tb.sv
